// ===== rtl/core/lgps_pkg.sv =====
`default_nettype none

package lgps_pkg;

    localparam int LEG_COUNT = 4;

    typedef enum logic [1:0] {
        GAIT_NONE  = 2'd0,
        GAIT_STAND = 2'd1,
        GAIT_WALK  = 2'd2,
        GAIT_TROT  = 2'd3
    } gait_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LEG,
        ST_LDIV,
        ST_EMIT
    } state_t;

    // configuration register indexes
    localparam logic [2:0] REG_IDLE_PERIOD = 3'd0;
    localparam logic [2:0] REG_WALK_PERIOD = 3'd1;
    localparam logic [2:0] REG_TROT_PERIOD = 3'd2;
    localparam logic [2:0] REG_WALK_RATIO  = 3'd3;
    localparam logic [2:0] REG_TROT_RATIO  = 3'd4;

    localparam logic [23:0] IDLE_PERIOD_RST = 24'd1000000;
    localparam logic [23:0] WALK_PERIOD_RST = 24'd800000;
    localparam logic [23:0] TROT_PERIOD_RST = 24'd600000;
    localparam logic [15:0] WALK_RATIO_RST  = 16'd49152;
    localparam logic [15:0] TROT_RATIO_RST  = 16'd32768;

    localparam logic [16:0] Q16_ONE          = 17'h10000;
    localparam logic [15:0] SWITCH_THRESHOLD = 16'd62260;  // 0.95
    localparam logic [15:0] SNAP_THRESHOLD   = 16'd65209;  // 0.995

    // quotient bits minus one: 32 count bits + 16 phase bits, 16 progress bits
    localparam logic [5:0] MAIN_DIV_STEPS = 6'd47;
    localparam logic [5:0] LEG_DIV_STEPS  = 6'd15;

    localparam logic [1:0] LAST_LEG = 2'(LEG_COUNT - 1);

    function automatic logic [15:0] leg_offset(input gait_t gait, input logic [1:0] leg);
        logic [15:0] off;
        off = 16'd0;
        if (gait == GAIT_TROT) begin
            case (leg)
                2'd0:    off = 16'd32768;
                2'd1:    off = 16'd0;
                2'd2:    off = 16'd0;
                2'd3:    off = 16'd32768;
                default: off = 16'd0;
            endcase
        end else begin
            case (leg)
                2'd0:    off = 16'd16384;
                2'd1:    off = 16'd49152;
                2'd2:    off = 16'd32768;
                2'd3:    off = 16'd0;
                default: off = 16'd0;
            endcase
        end
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lgps_req_if.sv =====
`default_nettype none

interface lgps_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_us;
    logic        change_request;
    logic [1:0]  desired_gait;

    modport source (output valid, time_us, change_request, desired_gait, input ready);
    modport sink   (input valid, time_us, change_request, desired_gait, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lgps_res_if.sv =====
`default_nettype none

interface lgps_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  leg_index;
    logic        in_stance;
    logic [16:0] stance_progress;
    logic [16:0] swing_progress;
    logic [15:0] gait_phase;
    logic [15:0] cycle_count;
    logic [1:0]  active_gait;
    logic        last_leg;

    modport source (
        output valid, leg_index, in_stance, stance_progress, swing_progress,
               gait_phase, cycle_count, active_gait, last_leg,
        input  ready
    );
    modport sink (
        input  valid, leg_index, in_stance, stance_progress, swing_progress,
               gait_phase, cycle_count, active_gait, last_leg,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/legged_gait_phase_scheduler.sv =====
// Channel   | Dir | Payload                                              | Per request
// ----------+-----+------------------------------------------------------+------------
// req       | in  | time_us, change_request, desired_gait                | one
// res       | out | leg_index, in_stance, stance/swing_progress,         | four, legs
//           |     | gait_phase, cycle_count, active_gait, last_leg       | 0..3 in order
// cfg_*     | in  | write enable, register index, 24-bit data            | -
//
// One request at a time. A shared restoring divider yields one quotient bit per cycle:
// first 48 bits for cycle count and phase, then per leg a setup step, 16 bits of
// divide and an emit step; none and stand skip the leg divide. Emit holds while the
// result channel stalls. The next request is taken as soon as the fourth result
// sits in the output register. Reset (rst_n low, async) restores the register
// defaults and the stand gait; no clearing pass is needed.

`default_nettype none

module legged_gait_phase_scheduler
    import lgps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    lgps_req_if.sink         req,
    lgps_res_if.source       res
);

    state_t state_reg, state_next;

    // configuration registers
    logic [23:0] idle_period_reg, walk_period_reg, trot_period_reg;
    logic [15:0] walk_ratio_reg, trot_ratio_reg;

    // scheduler state
    logic [31:0] start_reg, start_next;
    gait_t       gait_reg, gait_next;
    logic        pend_reg, pend_next;
    gait_t       pgait_reg, pgait_next;
    logic [15:0] prev_reg, prev_next;

    // work registers
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  leg_reg, leg_next;
    logic [23:0] rem_reg, rem_next;
    logic [31:0] num_reg, num_next;
    logic [23:0] div_reg, div_next;
    logic [47:0] quo_reg, quo_next;
    logic [15:0] ratio_reg, ratio_next;
    logic [15:0] phase_reg, phase_next;
    logic [15:0] cyc_reg, cyc_next;
    logic        stance_reg, stance_next;

    // output register
    logic        ovalid_reg, ovalid_next;
    logic [1:0]  oleg_reg, oleg_next;
    logic        ostance_reg, ostance_next;
    logic [16:0] osp_reg, osp_next;
    logic [16:0] owp_reg, owp_next;
    logic [15:0] ophase_reg, ophase_next;
    logic [15:0] ocyc_reg, ocyc_next;
    gait_t       ogait_reg, ogait_next;
    logic        olast_reg, olast_next;

    // shared divider step: shift in one dividend bit, trial subtract
    logic [24:0] rem_sh;
    logic [24:0] rem_diff;
    logic        qbit;

    assign rem_sh   = {rem_reg, num_reg[31]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign qbit     = rem_sh >= {1'b0, div_reg};

    // request-side decode
    logic        req_fire;
    logic        pend_in;
    gait_t       pgait_in;
    logic        do_switch;
    gait_t       gait_sel;
    logic [31:0] start_sel;
    logic [23:0] period_raw, period_sel;
    logic [15:0] ratio_sel;

    // leg-side decode
    logic        idle_gait;
    logic [15:0] degree;
    logic        leg_stance;
    logic [16:0] leg_prog;
    logic        out_free;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        pend_in   = req.change_request ? 1'b1 : pend_reg;
        pgait_in  = req.change_request ? gait_t'(req.desired_gait) : pgait_reg;
        do_switch = pend_in && (prev_reg >= SWITCH_THRESHOLD);
        gait_sel  = do_switch ? pgait_in : gait_reg;
        start_sel = do_switch ? req.time_us : start_reg;
        case (gait_sel)
            GAIT_WALK:
            begin
                period_raw = walk_period_reg;
                ratio_sel  = walk_ratio_reg;
            end
            GAIT_TROT:
            begin
                period_raw = trot_period_reg;
                ratio_sel  = trot_ratio_reg;
            end
            default:
            begin
                period_raw = idle_period_reg;
                ratio_sel  = 16'd0;
            end
        endcase
        // treat a zero period as one microsecond
        period_sel = (period_raw == 24'd0) ? 24'd1 : period_raw;
    end

    assign idle_gait  = (gait_reg == GAIT_NONE) || (gait_reg == GAIT_STAND);
    assign degree     = phase_reg - leg_offset(gait_reg, leg_reg);
    assign leg_stance = degree < ratio_reg;
    // snap 0.995 and above to one
    assign leg_prog   = (quo_reg[15:0] >= SNAP_THRESHOLD) ? Q16_ONE : {1'b0, quo_reg[15:0]};
    assign out_free   = !ovalid_reg || res.ready;

    always_comb
    begin
        state_next   = state_reg;
        start_next   = start_reg;
        gait_next    = gait_reg;
        pend_next    = pend_reg;
        pgait_next   = pgait_reg;
        prev_next    = prev_reg;
        cnt_next     = cnt_reg;
        leg_next     = leg_reg;
        rem_next     = rem_reg;
        num_next     = num_reg;
        div_next     = div_reg;
        quo_next     = quo_reg;
        ratio_next   = ratio_reg;
        phase_next   = phase_reg;
        cyc_next     = cyc_reg;
        stance_next  = stance_reg;
        ovalid_next  = ovalid_reg && !res.ready;
        oleg_next    = oleg_reg;
        ostance_next = ostance_reg;
        osp_next     = osp_reg;
        owp_next     = owp_reg;
        ophase_next  = ophase_reg;
        ocyc_next    = ocyc_reg;
        ogait_next   = ogait_reg;
        olast_next   = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    // latch the request, switch gait once the last phase passed 0.95
                    pend_next  = pend_in && !do_switch;
                    pgait_next = pgait_in;
                    gait_next  = gait_sel;
                    start_next = start_sel;
                    ratio_next = ratio_sel;
                    rem_next   = 24'd0;
                    num_next   = req.time_us - start_sel;
                    div_next   = period_sel;
                    cnt_next   = MAIN_DIV_STEPS;
                    state_next = ST_DIV;
                end
            end

            ST_DIV, ST_LDIV:
            begin
                rem_next = qbit ? rem_diff[23:0] : rem_sh[23:0];
                num_next = {num_reg[30:0], 1'b0};
                quo_next = {quo_reg[46:0], qbit};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    if (state_reg == ST_DIV)
                    begin
                        // upper 32 quotient bits count cycles, lower 16 give the phase
                        phase_next = quo_next[15:0];
                        prev_next  = quo_next[15:0];
                        cyc_next   = (|quo_next[47:32]) ? 16'hFFFF : quo_next[31:16];
                        leg_next   = 2'd0;
                        state_next = ST_LEG;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_LEG:
            begin
                if (idle_gait)
                begin
                    stance_next = 1'b1;
                    state_next  = ST_EMIT;
                end else begin
                    // remainder starts below the divisor, so only 16 fraction bits remain
                    stance_next = leg_stance;
                    rem_next    = leg_stance ? {8'd0, degree}
                                             : {8'd0, degree - ratio_reg};
                    div_next    = leg_stance ? {8'd0, ratio_reg}
                                             : {7'd0, Q16_ONE - {1'b0, ratio_reg}};
                    num_next    = 32'd0;
                    cnt_next    = LEG_DIV_STEPS;
                    state_next  = ST_LDIV;
                end
            end

            ST_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    oleg_next    = leg_reg;
                    ostance_next = stance_reg;
                    if (idle_gait)
                    begin
                        osp_next = Q16_ONE;
                        owp_next = 17'd0;
                    end else begin
                        osp_next = stance_reg ? leg_prog : Q16_ONE;
                        owp_next = stance_reg ? Q16_ONE : leg_prog;
                    end
                    ophase_next = phase_reg;
                    ocyc_next   = cyc_reg;
                    ogait_next  = gait_reg;
                    olast_next  = (leg_reg == LAST_LEG);
                    if (leg_reg == LAST_LEG)
                    begin
                        state_next = ST_IDLE;
                    end else begin
                        leg_next   = leg_reg + 2'd1;
                        state_next = ST_LEG;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            start_reg  <= 32'd0;
            gait_reg   <= GAIT_STAND;
            pend_reg   <= 1'b0;
            pgait_reg  <= GAIT_NONE;
            prev_reg   <= 16'd0;
            cnt_reg    <= 6'd0;
            leg_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            start_reg  <= start_next;
            gait_reg   <= gait_next;
            pend_reg   <= pend_next;
            pgait_reg  <= pgait_next;
            prev_reg   <= prev_next;
            cnt_reg    <= cnt_next;
            leg_reg    <= leg_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_period_reg <= IDLE_PERIOD_RST;
            walk_period_reg <= WALK_PERIOD_RST;
            trot_period_reg <= TROT_PERIOD_RST;
            walk_ratio_reg  <= WALK_RATIO_RST;
            trot_ratio_reg  <= TROT_RATIO_RST;
        end else if (cfg_we)
        begin
            case (cfg_index)
                REG_IDLE_PERIOD: idle_period_reg <= cfg_data;
                REG_WALK_PERIOD: walk_period_reg <= cfg_data;
                REG_TROT_PERIOD: trot_period_reg <= cfg_data;
                REG_WALK_RATIO:  walk_ratio_reg  <= cfg_data[15:0];
                REG_TROT_RATIO:  trot_ratio_reg  <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        div_reg     <= div_next;
        quo_reg     <= quo_next;
        ratio_reg   <= ratio_next;
        phase_reg   <= phase_next;
        cyc_reg     <= cyc_next;
        stance_reg  <= stance_next;
        oleg_reg    <= oleg_next;
        ostance_reg <= ostance_next;
        osp_reg     <= osp_next;
        owp_reg     <= owp_next;
        ophase_reg  <= ophase_next;
        ocyc_reg    <= ocyc_next;
        ogait_reg   <= ogait_next;
        olast_reg   <= olast_next;
    end

    assign res.valid           = ovalid_reg;
    assign res.leg_index       = oleg_reg;
    assign res.in_stance       = ostance_reg;
    assign res.stance_progress = osp_reg;
    assign res.swing_progress  = owp_reg;
    assign res.gait_phase      = ophase_reg;
    assign res.cycle_count     = ocyc_reg;
    assign res.active_gait     = ogait_reg;
    assign res.last_leg        = olast_reg;

endmodule

`default_nettype wire

// ===== verif/lgps_checker.sv =====
`timescale 1ns / 1ps

module lgps_checker
    import lgps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    lgps_req_if              req,
    lgps_res_if              res,
    output int               mismatches,
    output int               legs_owed
);

    localparam int          LEGS          = 4;
    localparam logic [15:0] PHASE_SWITCH  = 16'd62260;
    localparam logic [32:0] PROGRESS_SNAP = 33'd65209;
    localparam logic [16:0] FULL_CYCLE    = 17'h10000;

    localparam logic [15:0] WALK_OFFSET [LEGS] = '{16'd16384, 16'd49152, 16'd32768, 16'd0};
    localparam logic [15:0] TROT_OFFSET [LEGS] = '{16'd32768, 16'd0, 16'd0, 16'd32768};

    typedef struct {
        logic [1:0]  leg;
        logic        stance;
        logic [16:0] stance_prog;
        logic [16:0] swing_prog;
        logic [15:0] phase;
        logic [15:0] cycles;
        gait_t       gait;
        logic        last;
    } leg_state_t;

    logic [23:0] idle_us;
    logic [23:0] walk_us;
    logic [23:0] trot_us;
    logic [15:0] walk_ratio;
    logic [15:0] trot_ratio;

    logic [31:0] start_us;
    gait_t       gait_now;
    logic        change_armed;
    gait_t       gait_queued;
    logic [15:0] last_phase;

    leg_state_t  owed_legs [$];

    function automatic logic [16:0] snap_progress(input logic [32:0] prog);
        return (prog >= PROGRESS_SNAP) ? FULL_CYCLE : prog[16:0];
    endfunction

    // Advance the gait state by one request and queue the four leg states it yields.
    task automatic predict_legs(input logic [31:0] now, input logic change, input gait_t want);
        logic [23:0] period;
        logic [15:0] ratio;
        logic [31:0] elapsed;
        logic [31:0] whole;
        logic [31:0] rem;
        logic [47:0] frac;
        logic [15:0] phase;
        logic [15:0] offset;
        logic [15:0] degree;
        logic [32:0] prog;
        leg_state_t  r;

        if (change) begin
            change_armed = 1'b1;
            gait_queued = want;
        end
        if (change_armed && last_phase >= PHASE_SWITCH) begin
            start_us = now;
            gait_now = gait_queued;
            change_armed = 1'b0;
            last_phase = 16'd0;
        end

        case (gait_now)
            GAIT_WALK: begin
                period = walk_us;
                ratio = walk_ratio;
            end
            GAIT_TROT: begin
                period = trot_us;
                ratio = trot_ratio;
            end
            default: begin
                period = idle_us;
                ratio = 16'd0;
            end
        endcase
        if (period == 24'd0)
            period = 24'd1;

        elapsed = now - start_us;
        whole = elapsed / {8'd0, period};
        rem = elapsed % {8'd0, period};
        frac = {rem, 16'd0} / {24'd0, period};
        phase = frac[15:0];
        last_phase = phase;

        for (int leg = 0; leg < LEGS; leg++) begin
            r.leg = 2'(leg);
            r.phase = phase;
            r.cycles = (whole > 32'd65535) ? 16'hFFFF : whole[15:0];
            r.gait = gait_now;
            r.last = (leg == LEGS - 1);
            if (gait_now == GAIT_WALK || gait_now == GAIT_TROT) begin
                offset = (gait_now == GAIT_TROT) ? TROT_OFFSET[leg] : WALK_OFFSET[leg];
                degree = phase - offset;
                if (degree < ratio) begin
                    prog = {1'b0, degree, 16'd0} / {17'd0, ratio};
                    r.stance = 1'b1;
                    r.stance_prog = snap_progress(prog);
                    r.swing_prog = FULL_CYCLE;
                end else begin
                    prog = {1'b0, 16'(degree - ratio), 16'd0} / (33'h10000 - {17'd0, ratio});
                    r.stance = 1'b0;
                    r.stance_prog = FULL_CYCLE;
                    r.swing_prog = snap_progress(prog);
                end
            end else begin
                r.stance = 1'b1;
                r.stance_prog = FULL_CYCLE;
                r.swing_prog = 17'd0;
            end
            owed_legs.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        leg_state_t want;
        if (!rst_n) begin
            idle_us = 24'd1000000;
            walk_us = 24'd800000;
            trot_us = 24'd600000;
            walk_ratio = 16'd49152;
            trot_ratio = 16'd32768;
            start_us = 32'd0;
            gait_now = GAIT_STAND;
            change_armed = 1'b0;
            gait_queued = GAIT_NONE;
            last_phase = 16'd0;
            owed_legs.delete();
            mismatches = 0;
            legs_owed = 0;
        end else begin
            if (res.valid && res.ready) begin
                if (owed_legs.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual leg %0d",
                             $time, res.leg_index);
                end else begin
                    want = owed_legs.pop_front();
                    check_field("leg_index", want.leg, res.leg_index);
                    check_field("in_stance", want.stance, res.in_stance);
                    check_field("stance_progress", want.stance_prog, res.stance_progress);
                    check_field("swing_progress", want.swing_prog, res.swing_progress);
                    check_field("gait_phase", want.phase, res.gait_phase);
                    check_field("cycle_count", want.cycles, res.cycle_count);
                    check_field("active_gait", want.gait, res.active_gait);
                    check_field("last_leg", want.last, res.last_leg);
                end
            end
            if (req.valid && req.ready)
                predict_legs(req.time_us, req.change_request, gait_t'(req.desired_gait));
            if (cfg_we) begin
                case (cfg_index)
                    REG_IDLE_PERIOD: idle_us = cfg_data;
                    REG_WALK_PERIOD: walk_us = cfg_data;
                    REG_TROT_PERIOD: trot_us = cfg_data;
                    REG_WALK_RATIO:  walk_ratio = cfg_data[15:0];
                    REG_TROT_RATIO:  trot_ratio = cfg_data[15:0];
                    default: ;
                endcase
            end
            legs_owed = owed_legs.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lgps_pkg::*;

    // Cycles without any handshake before the run is declared hung. The limit covers
    // the slowest request plus four result stall bursts, a send gap and the long
    // receiver hold, many times over.
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 150;

    // Indexes past the last register: writes there must be dropped by the block.
    localparam logic [2:0] REG_SPARE_A = 3'd5;
    localparam logic [2:0] REG_SPARE_B = 3'd6;
    localparam logic [2:0] REG_SPARE_C = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    lgps_req_if req_ch ();
    lgps_res_if res_ch ();

    int          mismatches;
    int          legs_owed;
    int          tx_gap_pct;
    int          rx_gap_pct;
    bit          long_hold_req;
    logic [31:0] clock_us;
    int          quiet_cycles = 0;

    legged_gait_phase_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    lgps_checker leg_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .res        (res_ch),
        .mismatches (mismatches),
        .legs_owed  (legs_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // Result side: random stall bursts, plus one long hold on request from the
    // stimulus so the block fills up and backs up the sender.
    initial
    begin
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD - 1;
                res_ch.ready <= 1'b0;
            end
            else if (rx_gap_pct > 0 && $urandom_range(0, 99) < rx_gap_pct)
            begin
                hold = $urandom_range(0, 10);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Hang detection: count cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL legged_gait_phase_scheduler");
            $finish;
        end
    end

    // Offer one request and hold it until the block takes it. A random idle burst
    // may come first; valid stays high between back-to-back requests.
    task automatic send_request(input logic [31:0] t, input logic change, input gait_t gait);
        int gap;
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.time_us <= t;
        req_ch.change_request <= change;
        req_ch.desired_gait <= gait;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drop valid and wait until every leg result owed has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (legs_owed == 0);
        @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [23:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_gait_regs(input logic [23:0] idle_us, input logic [23:0] walk_us,
                                  input logic [23:0] trot_us, input logic [23:0] walk_r,
                                  input logic [23:0] trot_r);
        put_reg(REG_IDLE_PERIOD, idle_us);
        put_reg(REG_WALK_PERIOD, walk_us);
        put_reg(REG_TROT_PERIOD, trot_us);
        put_reg(REG_WALK_RATIO, walk_r);
        put_reg(REG_TROT_RATIO, trot_r);
        cfg_we <= 1'b0;
    endtask

    // Next timestamp: mostly a forward step from the running cursor, so the phase
    // sweeps through the switch window; some steps go backwards, some jump anywhere,
    // and a few land on the ends of the 32-bit range.
    function automatic logic [31:0] next_time(input logic [31:0] step_max);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            clock_us = clock_us + $urandom_range(0, step_max);
        else if (pick < 88)
            clock_us = clock_us - $urandom_range(0, step_max);
        else if (pick < 96)
            clock_us = $urandom;
        else
            clock_us = pick[0] ? 32'hFFFF_FFFF : 32'h0;
        return clock_us;
    endfunction

    // Random requests with occasional gait changes; hold_at picks the request at
    // which the receiver goes into its long hold (negative for none).
    task automatic run_items(input int count, input logic [31:0] step_max, input int hold_at);
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                long_hold_req = 1'b1;
            send_request(next_time(step_max), $urandom_range(0, 99) < 20,
                         gait_t'($urandom_range(0, 3)));
        end
        drain_results();
    endtask

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.time_us <= 32'd0;
        req_ch.change_request <= 1'b0;
        req_ch.desired_gait <= GAIT_NONE;
        cfg_we <= 1'b0;
        cfg_index <= REG_IDLE_PERIOD;
        cfg_data <= 24'd0;
        tx_gap_pct = 20;
        rx_gap_pct = 20;
        long_hold_req = 1'b0;
        clock_us = 32'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through every gait on the reset periods (1 s, 0.8 s, 0.6 s).
        // Each change is requested late in a cycle so the switch fires on the next request.
        send_request(32'd0, 1'b0, GAIT_STAND);
        send_request(32'd970000, 1'b1, GAIT_WALK);      // latch walk at phase 0.97
        send_request(32'd980000, 1'b0, GAIT_NONE);      // switch to walk here
        send_request(32'd1380000, 1'b0, GAIT_NONE);     // walk at half cycle
        send_request(32'd1770000, 1'b1, GAIT_TROT);     // latch trot late in the cycle
        send_request(32'd1775000, 1'b1, GAIT_TROT);     // repeat it, switch lands here
        send_request(32'd2075000, 1'b0, GAIT_NONE);     // trot at half cycle
        send_request(32'd2365000, 1'b1, GAIT_NONE);
        send_request(32'd2370000, 1'b0, GAIT_WALK);     // switch to none
        send_request(32'd3350000, 1'b1, GAIT_STAND);
        send_request(32'd3360000, 1'b0, GAIT_WALK);     // switch to stand
        send_request(32'd4350000, 1'b1, GAIT_STAND);    // same gait again restarts time
        send_request(32'd4355000, 1'b0, GAIT_NONE);
        send_request(32'd4000000, 1'b0, GAIT_NONE);     // time runs backwards and wraps
        send_request(32'hFFFF_FFFF, 1'b1, GAIT_WALK);
        send_request(32'd0, 1'b0, GAIT_TROT);
        drain_results();

        // Extremes: shortest idle period (cycle count saturates), longest walk
        // period, a zero trot period, full walk ratio and a zero trot ratio (the
        // upper data bits must be masked off). Spare indexes must be ignored.
        load_gait_regs(24'd1, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 24'hFF_0000);
        put_reg(REG_SPARE_A, 24'hFF_FFFF);
        put_reg(REG_SPARE_B, 24'h00_0001);
        put_reg(REG_SPARE_C, 24'hFF_FFFF);
        cfg_we <= 1'b0;
        run_items(40, 32'hFFFF_FFFF, -1);

        // Very short periods so gait switches come often; stall the receiver for a
        // long stretch partway through while requests keep coming.
        load_gait_regs(24'd37, 24'd53, 24'd29, 24'd40000, 24'd20000);
        run_items(120, 32'd8, 30);

        // A stretch with no idling on either side, smallest and largest ratios.
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        load_gait_regs(24'd1200, 24'd900, 24'd700, 24'd1, 24'd65535);
        run_items(80, 32'd40, -1);

        // Random register values, including junk in the upper ratio bits.
        tx_gap_pct = 30;
        rx_gap_pct = 30;
        load_gait_regs(24'($urandom), 24'($urandom), 24'($urandom),
                       24'($urandom), 24'($urandom));
        run_items(80, 32'hFFFF_FFFF, -1);

        // Back to the defaults, no idling for the last part.
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        load_gait_regs(IDLE_PERIOD_RST, WALK_PERIOD_RST, TROT_PERIOD_RST,
                       {8'd0, WALK_RATIO_RST}, {8'd0, TROT_RATIO_RST});
        run_items(80, 32'd40000, -1);

        // Give any stray result time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && legs_owed == 0)
            $display("PASS legged_gait_phase_scheduler");
        else
            $display("FAIL legged_gait_phase_scheduler");
        $finish;
    end

endmodule
